// ----- design/mnrr_pkg.sv -----
`default_nettype none

package mnrr_pkg;

    localparam int NUM_NOTES     = 128;
    localparam int NOTE_W        = 7;
    localparam int MOD_REQ_W     = 2;
    localparam int VEL_W         = 7;
    localparam int BEND_W        = 14;
    localparam int OFFSET_W      = 16;
    localparam int CHAN_W        = 5;
    localparam int VALUE_W       = 14;
    localparam int NUM_CHAN_REGS = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int MAX_RESULTS   = 4;
    localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);
    localparam int RES_IDX_W     = $clog2(MAX_RESULTS);

    localparam logic [CHAN_W-1:0] CHAN_MIN = CHAN_W'(1);
    localparam logic [CHAN_W-1:0] CHAN_MAX = CHAN_W'(16);
    localparam logic [VEL_W-1:0]  VEL_MIN  = VEL_W'(1);

    typedef enum logic [2:0] {
        MODE_NOTE_ON  = 3'd0,
        MODE_NOTE_OFF = 3'd1,
        MODE_BEND     = 3'd2,
        MODE_SUSTAIN  = 3'd3,
        MODE_ENABLE   = 3'd4,
        MODE_CLEAR    = 3'd5,
        MODE_RELEASE  = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        KIND_ON   = 2'd0,
        KIND_OFF  = 2'd1,
        KIND_BEND = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [CHAN_W-1:0]    channel;
        logic [NOTE_W-1:0]    note;
        logic [VALUE_W-1:0]   value;
        logic [OFFSET_W-1:0]  offset;
        logic                 last;
    } t_result;

    // Handshake status of the result queue as seen by the processing stage.
    typedef struct packed {
        logic free;
    } t_queue_status;

endpackage

`default_nettype wire

// ----- design/mnrr_count_ram.sv -----
`default_nettype none

module mnrr_count_ram
    import mnrr_pkg::*;
#(
    parameter int ROW_W = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rd_en,
    input  wire logic [NOTE_W-1:0] i_rd_addr,
    output logic      [ROW_W-1:0]  o_rd_data,
    input  wire logic              i_wr_en,
    input  wire logic [NOTE_W-1:0] i_wr_addr,
    input  wire logic [ROW_W-1:0]  i_wr_data
);

    logic [ROW_W-1:0]     r_mem [NUM_NOTES];
    logic [NUM_NOTES-1:0] r_valid;
    logic [ROW_W-1:0]     r_rd_data;
    logic                 r_rd_valid;
    logic                 r_fwd;
    logic [ROW_W-1:0]     r_fwd_data;

    // A row never written since reset reads as zero through its valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
                r_fwd      <= i_wr_en && (i_wr_addr == i_rd_addr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    // A write to the row being read in the same cycle is bypassed.
    assign o_rd_data = r_fwd ? r_fwd_data : (r_rd_valid ? r_rd_data : '0);

endmodule

`default_nettype wire

// ----- design/mnrr_result_queue.sv -----
`default_nettype none

module mnrr_result_queue
    import mnrr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire logic [RES_CNT_W-1:0] i_count,
    input  wire t_result              i_items [MAX_RESULTS],
    output t_queue_status             o_status,
    output logic                      o_valid,
    output t_result                   o_item,
    input  wire logic                 i_ready
);

    logic [RES_CNT_W-1:0] r_cnt;
    t_result              r_items [MAX_RESULTS];
    logic                 xfer;

    assign xfer            = (r_cnt != '0) && i_ready;
    assign o_status.free   = (r_cnt == '0) || ((r_cnt == RES_CNT_W'(1)) && i_ready);
    assign o_valid         = (r_cnt != '0);
    assign o_item          = r_items[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_count;
        end else if (xfer) begin
            r_cnt <= r_cnt - RES_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_items <= i_items;
        end else if (xfer) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                r_items[i] <= r_items[i + 1];
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/midi_note_refcount_router.sv -----
`default_nettype none

// Channel     Dir  Width            Contents
// s_axis      in   tdata 48, tuser 3  note, bend, sustain, enable, clear and release
// m_axis      out  tdata 48, tuser 2  note-on, note-off and pitch-bend events, tlast
// cfg         in   index 2, data 5    MIDI channel of each sound module
//
// An item is registered when accepted and its note row is read from the count RAM in
// the same cycle; once the result queue can take it, the processing stage updates the
// row and loads the queue. A new item can be accepted every cycle while the queue can
// take the one before it, and the first result is offered from the queue registers once
// they are loaded. Results leave one per cycle while m_axis is ready, so an item with
// several results holds the queue until its last result has left.
// Reset is synchronous; the count RAM keeps one valid bit per note row, so no
// clearing pass is needed and items are accepted right after reset.
// Input stalls only when the processing stage holds an item the queue cannot take.

module midi_note_refcount_router
    import mnrr_pkg::*;
#(
    parameter int NUM_MODULES = 4,
    parameter int COUNT_WIDTH = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // tdata, from bit 0: module_req(2) note(7) velocity(7) bend_value(14)
    // switch_on(1) sample_offset(16), then one zero bit
    input  wire logic [47:0]          i_s_axis_tdata,
    // tuser: mode(3)
    input  wire logic [2:0]           i_s_axis_tuser,
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // tdata, from bit 0: channel(5) note_out(7) value(14) event_offset(16),
    // then six zero bits
    output logic      [47:0]          o_m_axis_tdata,
    // tuser: msg_kind(2)
    output logic      [1:0]           o_m_axis_tuser,
    output logic                      o_m_axis_tlast,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CHAN_W-1:0]    i_cfg_data
);

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] held;
        logic [COUNT_WIDTH-1:0] sound;
    } t_cnt_pair;

    localparam int ROW_W     = NUM_MODULES * 2 * COUNT_WIDTH;
    localparam int BEND_SCAN = (NUM_MODULES < 8) ? NUM_MODULES : 8;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Channel registers are clamped to the legal MIDI range on write.
    function automatic logic [CHAN_W-1:0] clamp_chan(input logic [CHAN_W-1:0] v);
        logic [CHAN_W-1:0] c;
        c = v;
        if (c < CHAN_MIN) begin
            c = CHAN_MIN;
        end
        if (c > CHAN_MAX) begin
            c = CHAN_MAX;
        end
        return c;
    endfunction

    logic [CHAN_W-1:0]      r_chan [NUM_CHAN_REGS];
    logic [NUM_MODULES-1:0] r_enabled;
    logic                   r_sustain;

    logic                   r_s1_valid;
    t_mode                  r_s1_mode;
    logic [MOD_REQ_W-1:0]   r_s1_mod;
    logic [NOTE_W-1:0]      r_s1_note;
    logic [VEL_W-1:0]       r_s1_vel;
    logic [BEND_W-1:0]      r_s1_bend;
    logic                   r_s1_sw;
    logic [OFFSET_W-1:0]    r_s1_offset;

    logic                   s_accept;
    logic                   s1_advance;
    t_queue_status          q_status;
    t_result                q_item;

    logic [ROW_W-1:0]       rd_data;
    t_cnt_pair [NUM_MODULES-1:0] rd_row;
    t_cnt_pair [NUM_MODULES-1:0] new_row;

    logic                   in_range;
    logic                   en_m;
    logic [COUNT_WIDTH-1:0] cnt;
    logic [COUNT_WIDTH-1:0] held;
    logic [COUNT_WIDTH-1:0] cnt_new;
    logic [COUNT_WIDTH-1:0] held_new;
    logic                   row_wr;
    logic [VEL_W-1:0]       vel_clamped;
    t_result                res_items [MAX_RESULTS];
    logic [RES_CNT_W-1:0]   res_cnt;
    logic [RES_CNT_W-1:0]   last_idx;
    logic [CHAN_W-1:0]      bend_chan;

    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign s1_advance      = r_s1_valid && q_status.free;
    assign o_s_axis_tready = !r_s1_valid || q_status.free;

    // Configuration, module enables and the pedal state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHAN_REGS; i++) begin
                r_chan[i] <= CHAN_MIN;
            end
            r_enabled  <= '0;
            r_sustain  <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_chan[i_cfg_index] <= clamp_chan(i_cfg_data);
            end
            if (s1_advance) begin
                if (r_s1_mode == MODE_SUSTAIN) begin
                    r_sustain <= r_s1_sw;
                end
                if (r_s1_mode == MODE_ENABLE) begin
                    for (int k = 0; k < NUM_MODULES; k++) begin
                        if (32'(r_s1_mod) == k) begin
                            r_enabled[k] <= r_s1_sw;
                        end
                    end
                end
            end
            if (s_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_mode   <= t_mode'(i_s_axis_tuser);
            r_s1_mod    <= i_s_axis_tdata[1:0];
            r_s1_note   <= i_s_axis_tdata[8:2];
            r_s1_vel    <= i_s_axis_tdata[15:9];
            r_s1_bend   <= i_s_axis_tdata[29:16];
            r_s1_sw     <= i_s_axis_tdata[30];
            r_s1_offset <= i_s_axis_tdata[46:31];
        end
    end

    mnrr_count_ram #(
        .ROW_W (ROW_W)
    ) u_count_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (s_accept),
        .i_rd_addr (i_s_axis_tdata[8:2]),
        .o_rd_data (rd_data),
        .i_wr_en   (s1_advance && row_wr),
        .i_wr_addr (r_s1_note),
        .i_wr_data (new_row)
    );

    assign rd_row = rd_data;

    // Pick out the counts and enable of the addressed module.
    always_comb begin
        in_range = (32'(r_s1_mod) < NUM_MODULES);
        en_m     = 1'b0;
        cnt      = '0;
        held     = '0;
        for (int k = 0; k < NUM_MODULES; k++) begin
            if (32'(r_s1_mod) == k) begin
                en_m = r_enabled[k];
                cnt  = rd_row[k].sound;
                held = rd_row[k].held;
            end
        end
        vel_clamped = (r_s1_vel < VEL_MIN) ? VEL_MIN : r_s1_vel;
    end

    // Count update and result list for the item in the processing stage.
    always_comb begin
        cnt_new  = cnt;
        held_new = held;
        row_wr   = 1'b0;
        res_cnt  = '0;
        last_idx = '0;
        bend_chan = CHAN_MIN;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            res_items[i].kind    = KIND_OFF;
            res_items[i].channel = r_chan[r_s1_mod];
            res_items[i].note    = r_s1_note;
            res_items[i].value   = '0;
            res_items[i].offset  = r_s1_offset;
            res_items[i].last    = 1'b0;
        end

        unique case (r_s1_mode)
            MODE_BEND: begin
                // Enabled modules in ascending order, at most one result slot each.
                for (int k = 0; k < BEND_SCAN; k++) begin
                    bend_chan = (k < NUM_CHAN_REGS) ? r_chan[k[CFG_IDX_W-1:0]] : CHAN_MIN;
                    if (r_enabled[k] && (res_cnt < RES_CNT_W'(MAX_RESULTS))) begin
                        res_items[res_cnt[RES_IDX_W-1:0]].kind    = KIND_BEND;
                        res_items[res_cnt[RES_IDX_W-1:0]].channel = bend_chan;
                        res_items[res_cnt[RES_IDX_W-1:0]].note    = '0;
                        res_items[res_cnt[RES_IDX_W-1:0]].value   = r_s1_bend;
                        res_cnt = res_cnt + RES_CNT_W'(1);
                    end
                end
            end
            MODE_NOTE_ON: begin
                if (in_range && en_m) begin
                    row_wr = 1'b1;
                    if (cnt != COUNT_MAX) begin
                        cnt_new = cnt + COUNT_WIDTH'(1);
                    end
                    if (cnt == '0) begin
                        res_items[0].kind  = KIND_ON;
                        res_items[0].value = VALUE_W'(vel_clamped);
                        res_cnt = RES_CNT_W'(1);
                    end
                end
            end
            MODE_NOTE_OFF: begin
                if (in_range && (cnt != '0)) begin
                    row_wr = 1'b1;
                    if (r_sustain) begin
                        if (held != COUNT_MAX) begin
                            held_new = held + COUNT_WIDTH'(1);
                        end
                    end else begin
                        cnt_new = cnt - COUNT_WIDTH'(1);
                        if ((cnt == COUNT_WIDTH'(1)) && en_m) begin
                            res_cnt = RES_CNT_W'(1);
                        end
                    end
                end
            end
            MODE_CLEAR: begin
                if (in_range) begin
                    row_wr   = 1'b1;
                    cnt_new  = '0;
                    held_new = '0;
                    if ((cnt != '0) || (held != '0)) begin
                        res_cnt = RES_CNT_W'(1);
                    end
                end
            end
            MODE_RELEASE: begin
                if (in_range && (held != '0)) begin
                    row_wr   = 1'b1;
                    cnt_new  = (cnt > held) ? (cnt - held) : '0;
                    held_new = '0;
                    if ((cnt <= held) && en_m) begin
                        res_cnt = RES_CNT_W'(1);
                    end
                end
            end
            default: begin
                // Sustain and enable only change flags; the unused mode does nothing.
            end
        endcase

        if (res_cnt != '0) begin
            last_idx = res_cnt - RES_CNT_W'(1);
            res_items[last_idx[RES_IDX_W-1:0]].last = 1'b1;
        end

        for (int k = 0; k < NUM_MODULES; k++) begin
            new_row[k] = rd_row[k];
            if (32'(r_s1_mod) == k) begin
                new_row[k].sound = cnt_new;
                new_row[k].held  = held_new;
            end
        end
    end

    mnrr_result_queue u_result_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (s1_advance && (res_cnt != '0)),
        .i_count  (res_cnt),
        .i_items  (res_items),
        .o_status (q_status),
        .o_valid  (o_m_axis_tvalid),
        .o_item   (q_item),
        .i_ready  (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {6'b0, q_item.offset, q_item.value, q_item.note, q_item.channel};
    assign o_m_axis_tuser = q_item.kind;
    assign o_m_axis_tlast = q_item.last;

endmodule

`default_nettype wire
